// File: hdl/two_pole_resonant_bandpass_macros.svh
// Assertion macros shared by the checker of the two-pole resonant bandpass.
// Depends on nothing; included by the checker file.
`ifndef TWO_POLE_RESONANT_BANDPASS_MACROS_SVH
`define TWO_POLE_RESONANT_BANDPASS_MACROS_SVH

// same-cycle implication
`define TPRB_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPRB_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tprb_pkg.sv
// Package of the two-pole resonant bandpass: widths, register indexes and the cosine table.
// Depends on nothing; used by every module of the block.
package tprb_pkg;

    localparam int COS_DEPTH  = 1024;
    localparam int COS_KW     = $clog2(COS_DEPTH + 1);
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_W      = 16;
    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 32;
    localparam int HIST_W     = 40;
    localparam int MUL_W      = 34;
    localparam int DIV_STEPS  = 30;

    localparam logic [CFG_IDX_W-1:0] REG_CENTRE_FREQ = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_REL_BW      = CFG_IDX_W'(1);

    localparam longint PI_Q30  = 64'sd3373259426;
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint DENS [0:6] = '{182, 132, 90, 56, 30, 12, 2};

    typedef logic signed [COEF_W-1:0] cos_tab_t [0:COS_DEPTH];

    function automatic cos_tab_t build_cos_tab();
        cos_tab_t tab;
        longint   kk;
        longint   x;
        longint   x2;
        longint   t;
        logic     folded;
        for (int k = 0; k <= COS_DEPTH; k++) begin
            folded = (2 * k > COS_DEPTH);
            kk = folded ? longint'(COS_DEPTH - k) : longint'(k);
            x  = (PI_Q30 * kk) / COS_DEPTH;
            x2 = (x * x) >>> 30;
            t  = ONE_Q30;
            for (int i = 0; i < 7; i++) begin
                t = ONE_Q30 - ((x2 * t) >>> 30) / DENS[i];
            end
            tab[k] = folded ? COEF_W'(-t) : COEF_W'(t);
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

// File: hdl/tprb_mul.sv
// Shared signed multiplier with a registered product for the bandpass sequencer.
// Depends on tprb_pkg for the operand width.
module tprb_mul (
    input  logic                                    aclk,
    input  logic signed [tprb_pkg::MUL_W-1:0]       op_a,
    input  logic signed [tprb_pkg::MUL_W-1:0]       op_b,
    output logic signed [2*tprb_pkg::MUL_W-1:0]     prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

endmodule

// File: hdl/two_pole_resonant_bandpass.sv
// Top level of the two-pole resonant bandpass: sequencer, divider and sample datapath.
// Depends on tprb_pkg and tprb_mul.
//
// Usage:
//   s_valid/s_ready/s_sample_in take one signed 24-bit sample per beat.
//   m_valid/m_ready/m_sample_out give one filtered, saturated sample per input beat.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write centre_freq (index 0) or
//   rel_bandwidth (index 1); cfg_ready is always high, other indexes are dropped.
//   Write registers only while the block is idle.
// Timing:
//   m_valid rises as the result enters the output register and s_ready returns in
//   the same cycle, so no new beat is taken while a sample is in flight. The first
//   sample after reset or after a register write waits while the coefficients are
//   rebuilt with the shared multiplier and a 30-step restoring divider.
//   All multiplications of the coefficient and sample paths run through one 34x34
//   multiplier; each of the three sample products is formed from two partial products.
// Reset (aresetn low, synchronous) clears the history and registers and marks the
//   coefficients for rebuild. A finished sample waits in the output register while
//   m_ready is low; the next input beat is still taken and its result held until then.
module two_pole_resonant_bandpass (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [tprb_pkg::SAMPLE_W-1:0]    s_sample_in,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [tprb_pkg::SAMPLE_W-1:0]    m_sample_out,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [tprb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [tprb_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int PW = tprb_pkg::CFG_W + tprb_pkg::COS_KW;
    localparam int MW = tprb_pkg::MUL_W;
    localparam int CW = $clog2(tprb_pkg::DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE, S_C_ROM, S_C_W, S_C_B, S_C_R, S_C_CW, S_C_R2, S_C_DIV,
        S_C_B1, S_C_B1W, S_M_HI, S_M_LO, S_M_FIN, S_OUT
    } state_t;

    typedef enum logic [1:0] {TERM_FB1, TERM_FB2, TERM_GAIN} term_t;

    state_t                                 state_reg;
    term_t                                  term_reg;
    logic                                   stale_reg;
    logic                                   m_valid_reg;
    logic signed [tprb_pkg::SAMPLE_W-1:0]   m_sample_out_reg;
    logic [tprb_pkg::CFG_W-1:0]             cf_reg;
    logic [tprb_pkg::CFG_W-1:0]             rb_reg;
    logic signed [tprb_pkg::HIST_W-1:0]     prev_one_reg;
    logic signed [tprb_pkg::HIST_W-1:0]     prev_two_reg;
    logic signed [tprb_pkg::COEF_W-1:0]     b1_reg;
    logic signed [tprb_pkg::COEF_W-1:0]     b2_reg;
    logic signed [tprb_pkg::COEF_W-1:0]     a0_reg;
    logic signed [tprb_pkg::COEF_W-1:0]     tk_reg;
    logic signed [tprb_pkg::COEF_W-1:0]     tk1_reg;
    logic [31:0]                            w_reg;
    logic signed [31:0]                     r_reg;
    logic signed [31:0]                     cw_reg;
    logic [32:0]                            r2_reg;
    logic [33:0]                            rem_reg;
    logic [tprb_pkg::DIV_STEPS-1:0]         q_reg;
    logic [CW-1:0]                          cnt_reg;
    logic signed [tprb_pkg::SAMPLE_W-1:0]   x_reg;
    logic signed [46:0]                     sum_reg;
    logic signed [tprb_pkg::HIST_W-1:0]     y0_reg;
    logic signed [tprb_pkg::SAMPLE_W-1:0]   res_reg;
    logic [72:0]                            acc_reg;

    logic signed [MW-1:0]                   op_a;
    logic signed [MW-1:0]                   op_b;
    logic signed [2*MW-1:0]                 prod_reg;

    logic [PW-1:0]                          p_full;
    logic [tprb_pkg::COS_KW-1:0]            k_idx;
    logic [tprb_pkg::CFG_W-1:0]             frac;
    logic signed [32:0]                     tdiff;
    logic signed [34:0]                     r_full;
    logic signed [33:0]                     cw_full;
    logic signed [2*MW-1:0]                 b1_sh;
    logic signed [34:0]                     a0_full;
    logic [34:0]                            rem2;
    logic [34:0]                            dvs;
    logic signed [31:0]                     c_sel;
    logic signed [40:0]                     y_sel;
    logic [31:0]                            mc;
    logic [40:0]                            my;
    logic                                   neg;
    logic [72:0]                            acc_sum;
    logic [43:0]                            mag;
    logic signed [44:0]                     term_val;
    logic signed [46:0]                     y0_full;

    assign p_full  = PW'(cf_reg) * PW'(tprb_pkg::COS_DEPTH);
    assign k_idx   = p_full[tprb_pkg::CFG_W +: tprb_pkg::COS_KW];
    assign frac    = p_full[tprb_pkg::CFG_W-1:0];
    assign tdiff   = 33'(tk1_reg) - 33'(tk_reg);
    assign r_full  = 35'(tprb_pkg::ONE_Q30) - 35'(prod_reg[47:15]);
    assign cw_full = 34'(tk_reg) + 34'(prod_reg >>> 16);
    assign b1_sh   = prod_reg >>> 29;
    assign a0_full = 35'(tprb_pkg::ONE_Q30) - 35'(r2_reg);
    assign rem2    = {rem_reg, 1'b0};
    assign dvs     = 35'(r2_reg) + 35'(tprb_pkg::ONE_Q30);

    always_comb begin
        c_sel = b1_reg;
        y_sel = 41'(prev_one_reg);
        case (term_reg)
            TERM_FB1: begin
                c_sel = b1_reg;
                y_sel = 41'(prev_one_reg);
            end
            TERM_FB2: begin
                c_sel = b2_reg;
                y_sel = 41'(prev_two_reg);
            end
            TERM_GAIN: begin
                c_sel = a0_reg;
                y_sel = 41'(y0_reg) - 41'(prev_two_reg);
            end
            default: begin
                c_sel = b1_reg;
                y_sel = 41'(prev_one_reg);
            end
        endcase
    end

    assign mc       = c_sel[31] ? 32'(-c_sel) : 32'(c_sel);
    assign my       = y_sel[40] ? 41'(-y_sel) : 41'(y_sel);
    assign neg      = c_sel[31] ^ y_sel[40];
    assign acc_sum  = acc_reg + 73'(prod_reg[51:0]);
    assign mag      = acc_sum[72:29];
    assign term_val = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    assign y0_full  = sum_reg + 47'(term_val);

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (state_reg)
            S_C_ROM: begin
                op_a = MW'(tprb_pkg::PI_Q30);
                op_b = MW'(cf_reg);
            end
            S_C_B: begin
                op_a = MW'(w_reg);
                op_b = MW'(rb_reg);
            end
            S_C_R: begin
                op_a = MW'(tdiff);
                op_b = MW'(frac);
            end
            S_C_CW: begin
                op_a = MW'(r_reg);
                op_b = MW'(r_reg);
            end
            S_C_B1: begin
                op_a = MW'(q_reg);
                op_b = MW'(cw_reg);
            end
            S_M_HI: begin
                op_a = MW'(mc);
                op_b = MW'(my[40:20]);
            end
            S_M_LO, S_M_FIN: begin
                op_a = MW'(mc);
                op_b = MW'(my[19:0]);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    tprb_mul u_mul (
        .aclk     (aclk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod_reg)
    );

    always_ff @(posedge aclk) begin
        tk_reg  <= tprb_pkg::COS_TAB[k_idx];
        tk1_reg <= tprb_pkg::COS_TAB[k_idx + 1'b1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            term_reg     <= TERM_FB1;
            stale_reg    <= 1'b1;
            m_valid_reg  <= 1'b0;
            cf_reg       <= '0;
            rb_reg       <= '0;
            prev_one_reg <= '0;
            prev_two_reg <= '0;
            cnt_reg      <= '0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        x_reg    <= s_sample_in;
                        term_reg <= TERM_FB1;
                        state_reg <= stale_reg ? S_C_ROM : S_M_HI;
                    end
                end
                S_C_ROM: begin
                    state_reg <= S_C_W;
                end
                S_C_W: begin
                    w_reg     <= prod_reg[47:16];
                    state_reg <= S_C_B;
                end
                S_C_B: begin
                    state_reg <= S_C_R;
                end
                S_C_R: begin
                    r_reg     <= (r_full[34:31] == {4{r_full[31]}}) ? r_full[31:0]
                                                                    : 32'sh8000_0000;
                    state_reg <= S_C_CW;
                end
                S_C_CW: begin
                    cw_reg    <= cw_full[31:0];
                    state_reg <= S_C_R2;
                end
                S_C_R2: begin
                    r2_reg    <= prod_reg[62:30];
                    rem_reg   <= 34'(prod_reg[62:30]);
                    q_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_C_DIV;
                end
                S_C_DIV: begin
                    if (rem2 >= dvs) begin
                        rem_reg <= 34'(rem2 - dvs);
                        q_reg   <= {q_reg[tprb_pkg::DIV_STEPS-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem2[33:0];
                        q_reg   <= {q_reg[tprb_pkg::DIV_STEPS-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(tprb_pkg::DIV_STEPS - 1)) begin
                        state_reg <= S_C_B1;
                    end
                end
                S_C_B1: begin
                    b2_reg    <= 32'(-(34'(r2_reg[32:1])));
                    a0_reg    <= 32'(a0_full >>> 2);
                    state_reg <= S_C_B1W;
                end
                S_C_B1W: begin
                    if (b1_sh[2*MW-1:31] == {(2*MW-31){b1_sh[31]}}) begin
                        b1_reg <= b1_sh[31:0];
                    end else begin
                        b1_reg <= b1_sh[2*MW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                    end
                    stale_reg <= 1'b0;
                    state_reg <= S_M_HI;
                end
                S_M_HI: begin
                    state_reg <= S_M_LO;
                end
                S_M_LO: begin
                    acc_reg   <= {prod_reg[52:0], 20'b0};
                    state_reg <= S_M_FIN;
                end
                S_M_FIN: begin
                    state_reg <= S_M_HI;
                    case (term_reg)
                        TERM_FB1: begin
                            sum_reg  <= 47'(x_reg) + 47'(term_val);
                            term_reg <= TERM_FB2;
                        end
                        TERM_FB2: begin
                            if (y0_full[46:39] == {8{y0_full[39]}}) begin
                                y0_reg <= y0_full[39:0];
                            end else begin
                                y0_reg <= y0_full[46] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
                            end
                            term_reg <= TERM_GAIN;
                        end
                        default: begin
                            if (term_val[44:23] == {22{term_val[23]}}) begin
                                res_reg <= term_val[23:0];
                            end else begin
                                res_reg <= term_val[44] ? {1'b1, 23'b0} : {1'b0, {23{1'b1}}};
                            end
                            prev_two_reg <= prev_one_reg;
                            prev_one_reg <= y0_reg;
                            state_reg    <= S_OUT;
                        end
                    endcase
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_sample_out_reg <= res_reg;
                        m_valid_reg      <= 1'b1;
                        state_reg        <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg_valid) begin
                unique case (cfg_index)
                    tprb_pkg::REG_CENTRE_FREQ: begin
                        cf_reg    <= cfg_data[tprb_pkg::CFG_W-1:0];
                        stale_reg <= 1'b1;
                    end
                    tprb_pkg::REG_REL_BW: begin
                        rb_reg    <= cfg_data[tprb_pkg::CFG_W-1:0];
                        stale_reg <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;

endmodule

// File: hdl/tprb_checker.sv
// Port-level checker for the two-pole resonant bandpass, bound to the top level.
// Depends on tprb_pkg and two_pole_resonant_bandpass_macros.svh.
`include "two_pole_resonant_bandpass_macros.svh"

module tprb_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic signed [tprb_pkg::SAMPLE_W-1:0] s_sample_in,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [tprb_pkg::SAMPLE_W-1:0] m_sample_out,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready,
    input logic [tprb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input logic [tprb_pkg::CFG_DATA_W-1:0]      cfg_data
);

    `TPRB_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_sample_out), "output beat changed while stalled")
    `TPRB_ASSERT_NXT(a_busy_after_in, aclk, aresetn, s_valid && s_ready, !s_ready, "input taken while a sample is in flight")
    `TPRB_ASSERT_IMP(a_out_after_work, aclk, aresetn, $rose(m_valid), $past(!s_ready), "result appeared without work")

endmodule

bind two_pole_resonant_bandpass tprb_checker u_tprb_checker (.*);
